// File: design/pchr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pchr_pkg
// Shared types and constants for the patch code histogram root-log block.
// ----------------------------------------------------------------------------
package pchr_pkg;

    localparam int MAX_BINS_DEF   = 64;
    localparam int COUNT_BITS_DEF = 16;

    localparam int          CODE_W   = 6;
    localparam int          CFG_W    = 7;
    localparam int          VALUE_W  = 16;
    localparam logic [6:0]  CFG_RESET = 7'd64;

    localparam int          FRAC_W   = 30;
    localparam int          LOG_BITS = 24;
    localparam logic [31:0] EPS_Q30  = 32'd10737;
    localparam logic [31:0] LN2_Q32  = 32'd2977044472;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CNT_RD,
        ST_CNT_WR,
        ST_MAX_RD,
        ST_MAX_CMP,
        ST_EM_RD,
        ST_EM_GO,
        ST_EM_WAIT
    } pchr_state_t;

    typedef enum logic [2:0] {
        U_IDLE,
        U_DIV,
        U_SQRT,
        U_PREP,
        U_LOG,
        U_MUL,
        U_DONE
    } pchr_unit_state_t;

    typedef struct packed {
        logic start;
        logic ack;
    } pchr_unit_ctl_t;

endpackage

// File: design/patch_code_histogram_rootlog.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// patch_code_histogram_rootlog
// Per-patch code histogram with root-log normalized bin output.
// ----------------------------------------------------------------------------
// One item at a time. A code goes through a read and an update state and
// then back to idle. An item marked last_of_patch then starts a maximum
// scan, a read and a compare per bin in use, and then one result per bin.
// Each result goes through the shared root-log unit: 30 division steps, 31
// root steps, 24 log steps and a final scale, after a read and a start
// state per bin. An empty patch skips the division. A stalled output holds
// the next result back until the output is free. Bin storage is a
// single-port-write memory; per-bin valid flops clear the whole histogram
// together, at reset and at the end of each patch, so there is no clearing
// pass.
// ----------------------------------------------------------------------------
module patch_code_histogram_rootlog
    import pchr_pkg::*;
#(
    parameter int MAX_BINS   = MAX_BINS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [CFG_W-1:0]   cfg_write_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [CODE_W-1:0]  code,
    input  logic               last_of_patch,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [VALUE_W-1:0] feature_value,
    output logic [CODE_W-1:0]  bin_index,
    output logic               last
);

    localparam int ADDR_W = $clog2(MAX_BINS);
    localparam int NB_W   = $clog2(MAX_BINS + 1);

    pchr_state_t state_reg, state_next;

    logic [CFG_W-1:0]      cfg_reg;
    logic [CODE_W-1:0]     code_reg;
    logic                  lastin_reg;
    logic [ADDR_W-1:0]     b_reg, b_next;
    logic [COUNT_BITS-1:0] max_reg, max_next;
    logic [MAX_BINS-1:0]   valid_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [VALUE_W-1:0]    fv_reg;
    logic [CODE_W-1:0]     bi_reg;
    logic                  ol_reg;
    logic                  ov_reg;

    logic [COUNT_BITS-1:0] mem [MAX_BINS];
    logic [COUNT_BITS-1:0] rd_data;
    logic                  rd_valid;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  wr_en;
    logic [NB_W-1:0]       n_use;
    logic [COUNT_BITS-1:0] eff;
    logic                  in_acc;
    logic                  code_ok;
    logic                  b_last;
    logic                  out_free;
    logic                  load_out;
    logic                  clr_all;
    pchr_unit_ctl_t        u_ctl;
    logic                  u_done;
    logic [VALUE_W-1:0]    u_result;

    always_comb
    begin
        if (cfg_reg == '0)
            n_use = NB_W'(1);
        else if (cfg_reg > CFG_W'(MAX_BINS))
            n_use = NB_W'(MAX_BINS);
        else
            n_use = NB_W'(cfg_reg);
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign eff      = rd_valid ? rd_data : '0;
    assign code_ok  = {1'b0, code_reg} < 7'(n_use);
    assign b_last   = (NB_W'(b_reg) + NB_W'(1)) == n_use;
    assign out_free = !ov_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (in_acc) state_next = ST_CNT_RD;
            ST_CNT_RD:  state_next = ST_CNT_WR;
            ST_CNT_WR:  state_next = lastin_reg ? ST_MAX_RD : ST_IDLE;
            ST_MAX_RD:  state_next = ST_MAX_CMP;
            ST_MAX_CMP: state_next = b_last ? ST_EM_RD : ST_MAX_RD;
            ST_EM_RD:   state_next = ST_EM_GO;
            ST_EM_GO:   state_next = ST_EM_WAIT;
            ST_EM_WAIT:
                if (u_done && out_free) state_next = b_last ? ST_IDLE : ST_EM_RD;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        b_next    = b_reg;
        max_next  = max_reg;
        rd_addr   = b_reg;
        wr_en     = 1'b0;
        u_ctl     = '0;
        load_out  = 1'b0;
        clr_all   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                b_next   = '0;
                max_next = '0;
            end
            ST_CNT_RD:
            begin
                rd_addr = code_reg[ADDR_W-1:0];
            end
            ST_CNT_WR:
            begin
                rd_addr = code_reg[ADDR_W-1:0];
                wr_en   = code_ok && (eff != '1);
            end
            ST_MAX_CMP:
            begin
                if (eff > max_reg) max_next = eff;
                b_next = b_last ? '0 : b_reg + ADDR_W'(1);
            end
            ST_EM_GO:
            begin
                u_ctl.start = 1'b1;
            end
            ST_EM_WAIT:
            begin
                if (u_done && out_free)
                begin
                    u_ctl.ack = 1'b1;
                    load_out  = 1'b1;
                    clr_all   = b_last;
                    b_next    = b_reg + ADDR_W'(1);
                end
            end
            default:
            begin
                b_next = b_reg;
            end
        endcase
    end

    // bin storage, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en) mem[code_reg[ADDR_W-1:0]] <= eff + COUNT_BITS'(1);
        rd_data <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cfg_reg   <= CFG_RESET;
            valid_reg <= '0;
            ov_reg    <= 1'b0;
            rd_valid  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en) cfg_reg <= cfg_write_data;
            if (clr_all)
                valid_reg <= '0;
            else if (wr_en)
                valid_reg[code_reg[ADDR_W-1:0]] <= 1'b1;
            rd_valid <= valid_reg[rd_addr];
            if (load_out)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg   <= b_next;
        max_reg <= max_next;
        if (state_reg == ST_EM_RD || state_reg == ST_EM_GO) cnt_reg <= eff;
        if (in_acc)
        begin
            code_reg   <= code;
            lastin_reg <= last_of_patch;
        end
        if (load_out)
        begin
            fv_reg <= u_result;
            bi_reg <= CODE_W'(b_reg);
            ol_reg <= b_last;
        end
    end

    pchr_root_log #(
        .COUNT_BITS(COUNT_BITS)
    ) u_root_log (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (u_ctl),
        .count  (state_reg == ST_EM_GO ? eff : cnt_reg),
        .maxv   (max_reg),
        .done   (u_done),
        .result (u_result)
    );

    assign out_valid     = ov_reg;
    assign feature_value = fv_reg;
    assign bin_index     = bi_reg;
    assign last          = ol_reg;

endmodule

// File: design/pchr_root_log.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pchr_root_log
// Iterative unit: ratio by restoring division, bitwise square root,
// log2 by repeated squaring, then scale by ln 2 to Q0.16.
// ----------------------------------------------------------------------------
module pchr_root_log
    import pchr_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  pchr_unit_ctl_t          ctl,
    input  logic [COUNT_BITS-1:0]   count,
    input  logic [COUNT_BITS-1:0]   maxv,
    output logic                    done,
    output logic [VALUE_W-1:0]      result
);

    pchr_unit_state_t state_reg, state_next;

    logic [4:0]            step_reg, step_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [COUNT_BITS-1:0] max_reg, max_next;
    logic [30:0]           q_reg, q_next;
    logic [61:0]           v_reg, v_next;
    logic [61:0]           res_reg, res_next;
    logic [61:0]           bit_reg, bit_next;
    logic [30:0]           y_reg, y_next;
    logic [24:0]           lg_reg, lg_next;
    logic [VALUE_W-1:0]    result_reg, result_next;

    logic [COUNT_BITS:0]   div_t;
    logic                  div_ge;
    logic [61:0]           sq_sum;
    logic [31:0]           x_val;
    logic [61:0]           y_sq;
    logic [31:0]           y_sh;
    logic [56:0]           prod;

    always_comb
    begin
        div_t  = {rem_reg, 1'b0};
        div_ge = div_t >= {1'b0, max_reg};
        sq_sum = res_reg + bit_reg;
        x_val  = 32'h4000_0000 + {1'b0, res_reg[30:0]} + EPS_Q30;
        y_sq   = 62'(y_reg) * 62'(y_reg);
        y_sh   = y_sq[61:30];
        prod   = 57'(lg_reg) * 57'(LN2_Q32) + (57'(1) << 39);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            U_IDLE: if (ctl.start) state_next = (maxv == '0) ? U_SQRT : U_DIV;
            U_DIV:  if (step_reg == 5'(FRAC_W - 1)) state_next = U_SQRT;
            U_SQRT: if (step_reg == 5'(FRAC_W)) state_next = U_PREP;
            U_PREP: state_next = U_LOG;
            U_LOG:  if (step_reg == 5'(LOG_BITS - 1)) state_next = U_MUL;
            U_MUL:  state_next = U_DONE;
            U_DONE: if (ctl.ack) state_next = U_IDLE;
            default: state_next = U_IDLE;
        endcase
    end

    always_comb
    begin
        step_next   = step_reg + 5'd1;
        rem_next    = rem_reg;
        max_next    = max_reg;
        q_next      = q_reg;
        v_next      = v_reg;
        res_next    = res_reg;
        bit_next    = bit_reg;
        y_next      = y_reg;
        lg_next     = lg_reg;
        result_next = result_reg;
        case (state_reg)
            U_IDLE:
            begin
                step_next = '0;
                max_next  = maxv;
                if (count >= maxv)
                begin
                    q_next   = 31'd1;
                    rem_next = count - maxv;
                end
                else
                begin
                    q_next   = '0;
                    rem_next = count;
                end
                // empty patch: ratio is zero
                v_next   = '0;
                res_next = '0;
                bit_next = 62'(1) << 60;
            end
            U_DIV:
            begin
                rem_next = div_ge ? COUNT_BITS'(div_t - {1'b0, max_reg})
                                  : COUNT_BITS'(div_t);
                q_next   = {q_reg[29:0], div_ge};
                if (step_reg == 5'(FRAC_W - 1))
                begin
                    step_next = '0;
                    v_next    = {q_reg[29:0], div_ge, 31'd0} >> 1;
                    res_next  = '0;
                    bit_next  = 62'(1) << 60;
                end
            end
            U_SQRT:
            begin
                if (v_reg >= sq_sum)
                begin
                    v_next   = v_reg - sq_sum;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
            U_PREP:
            begin
                step_next = '0;
                if (x_val[31])
                begin
                    lg_next = 25'd1;
                    y_next  = x_val[31:1];
                end
                else
                begin
                    lg_next = '0;
                    y_next  = x_val[30:0];
                end
            end
            U_LOG:
            begin
                lg_next = {lg_reg[23:0], y_sh[31]};
                y_next  = y_sh[31] ? y_sh[31:1] : y_sh[30:0];
            end
            U_MUL:
            begin
                result_next = prod[55:40];
            end
            U_DONE:
            begin
                step_next = step_reg;
            end
            default:
            begin
                step_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        max_reg    <= max_next;
        q_reg      <= q_next;
        v_reg      <= v_next;
        res_reg    <= res_next;
        bit_reg    <= bit_next;
        y_reg      <= y_next;
        lg_reg     <= lg_next;
        result_reg <= result_next;
    end

    assign done   = (state_reg == U_DONE);
    assign result = result_reg;

endmodule

// File: design/pchr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pchr_checker
// Port-level checks for the patch code histogram root-log block.
// ----------------------------------------------------------------------------
module pchr_checker
    import pchr_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [VALUE_W-1:0] feature_value,
    input logic [CODE_W-1:0]  bin_index,
    input logic               last
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(feature_value)
            && $stable(bin_index) && $stable(last))
        else $error("stalled output item changed");

    // the block works on one item at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while busy");

    // ln(1 + sqrt(r) + eps) never rounds down to zero
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> feature_value != '0)
        else $error("zero feature value");

    // the top bin index can only be the end of a run
    a_top_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bin_index == '1 |-> last)
        else $error("top bin not marked last");

endmodule

bind patch_code_histogram_rootlog pchr_checker u_pchr_checker (.*);
